// ----- rtl/kfold_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfold_pkg: shared types and constants
// Payload structs, configuration struct and codes for the *442 fold block.
// ----------------------------------------------------------------------------
package kfold_pkg;

  localparam int COORD_W = 24;            // Q12.12 coordinate
  localparam int DX_W    = COORD_W + 1;   // coordinate minus origin
  localparam int CELL_W  = 23;
  localparam int CPR_W   = 15;
  localparam int ADDR_W  = 14;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // -1000.0 in Q12.12
  localparam logic signed [COORD_W-1:0] INVALID_MARK = COORD_W'(-32'sd4096000);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CELL_SIZE     = 2'd0,
    REG_ORIGIN_X      = 2'd1,
    REG_ORIGIN_Y      = 2'd2,
    REG_CELLS_PER_ROW = 2'd3
  } reg_t;

  typedef struct packed {
    op_t                        op;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic                       parity_in;
    logic                       pixel_valid;
    logic [ADDR_W-1:0]          cell_addr;
    logic                       cell_flip;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic                       out_parity;
    logic                       out_valid;
    logic                       cell_out_of_range;
  } out_item_t;

  // item after origin subtraction, queued between front and back
  typedef struct packed {
    op_t                        op;
    logic                       pixel_valid;
    logic                       parity;
    logic signed [DX_W-1:0]     dx;
    logic signed [DX_W-1:0]     dy;
    logic                       load_en;
    logic [ADDR_W-1:0]          cell_addr;
    logic                       cell_flip;
  } mid_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]          cell_size;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic [CPR_W-1:0]           cells_per_row;
  } cfg_t;

endpackage

// ----- rtl/kfold_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfold_fifo: show-ahead queue
// Array storage with a registered head stage; capacity is DEPTH plus one.
// ----------------------------------------------------------------------------
module kfold_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      cnt;
  logic [PW:0]      cnt_next;
  logic             head_v;
  logic [WIDTH-1:0] head_q;
  logic             wr;
  logic             pop_ok;
  logic             load_head;

  assign full      = (cnt == (PW + 1)'(DEPTH));
  assign wr        = push && !full;
  assign pop_ok    = pop && head_v;
  assign load_head = (cnt != '0) && (!head_v || pop_ok);
  assign empty     = !head_v;
  assign dout      = head_q;

  always_comb begin
    cnt_next = cnt;
    if (wr) begin
      cnt_next = cnt_next + 1'b1;
    end
    if (load_head) begin
      cnt_next = cnt_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
    if (load_head) begin
      head_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      head_v <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load_head) begin
        rd_ptr <= rd_ptr + 1'b1;
        head_v <= 1'b1;
      end else if (pop_ok) begin
        head_v <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/kfold_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfold_front: input stage
// Takes items, subtracts the origin and qualifies load addresses.
// ----------------------------------------------------------------------------
module kfold_front #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                 push,
  output logic                 full,
  input  kfold_pkg::in_item_t  din,
  input  kfold_pkg::cfg_t      cfg,
  output kfold_pkg::mid_item_t mid,
  output logic                 mid_push,
  input  logic                 mid_full
);
  import kfold_pkg::*;

  assign full     = mid_full;
  assign mid_push = push && !mid_full;

  always_comb begin
    mid.op          = din.op;
    mid.pixel_valid = din.pixel_valid;
    mid.parity      = din.parity_in;
    mid.dx          = {din.pos_x[COORD_W-1], din.pos_x}
                      - {cfg.origin_x[COORD_W-1], cfg.origin_x};
    mid.dy          = {din.pos_y[COORD_W-1], din.pos_y}
                      - {cfg.origin_y[COORD_W-1], cfg.origin_y};
    // loads past the table end are dropped
    mid.load_en     = (32'(din.cell_addr) < 32'(TABLE_DEPTH));
    mid.cell_addr   = din.cell_addr;
    mid.cell_flip   = din.cell_flip;
  end

endmodule

// ----- rtl/kfold_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfold_div: pipelined floor divider
// One quotient bit per stage, then a sign fix-up stage for negative input.
// ----------------------------------------------------------------------------
module kfold_div (
  input  logic                                clk,
  input  logic [kfold_pkg::CELL_W-1:0]        s,
  input  logic signed [kfold_pkg::DX_W-1:0]   d,
  output logic signed [kfold_pkg::DX_W-1:0]   q,
  output logic [kfold_pkg::CELL_W-1:0]        r
);
  import kfold_pkg::*;

  localparam int N = COORD_W;

  logic [CELL_W-1:0] rem_q [N];
  logic [N-1:0]      dvd_q [N];
  logic              neg_q [N];
  logic              neg_in;
  logic [N-1:0]      u;

  // floor(d/s) for d < 0 is -(~d / s) - 1, remainder s - 1 - (~d mod s)
  assign neg_in = d[DX_W-1];
  assign u      = neg_in ? ~d[N-1:0] : d[N-1:0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [CELL_W-1:0] rem_prev;
    logic [N-1:0]      dvd_prev;
    logic              neg_prev;
    logic [CELL_W:0]   trial;
    logic [CELL_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign dvd_prev = u;
      assign neg_prev = neg_in;
    end else begin : g_next
      assign rem_prev = rem_q[k-1];
      assign dvd_prev = dvd_q[k-1];
      assign neg_prev = neg_q[k-1];
    end

    assign trial = {rem_prev, dvd_prev[N-1]};
    assign diff  = trial - {1'b0, s};
    assign ge    = (trial >= {1'b0, s});

    always_ff @(posedge clk) begin
      rem_q[k] <= ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
      dvd_q[k] <= {dvd_prev[N-2:0], ge};
      neg_q[k] <= neg_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (neg_q[N-1]) begin
      q <= ~$signed({1'b0, dvd_q[N-1]});
      r <= s - CELL_W'(1) - rem_q[N-1];
    end else begin
      q <= $signed({1'b0, dvd_q[N-1]});
      r <= rem_q[N-1];
    end
  end

endmodule

// ----- rtl/kfold_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfold_back: fold pipeline
// Divides into cells, folds, looks up the flip table and forms results.
// ----------------------------------------------------------------------------
module kfold_back #(
  parameter int TABLE_DEPTH = 16384,
  parameter int CAP         = 65
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kfold_pkg::cfg_t      cfg,
  input  kfold_pkg::mid_item_t mid,
  input  logic                 mid_avail,
  output logic                 mid_pop,
  output kfold_pkg::out_item_t res,
  output logic                 res_push,
  input  logic                 res_taken
);
  import kfold_pkg::*;

  localparam int DIV_LAT = COORD_W + 1;
  localparam int TAW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CRW     = $clog2(CAP + 1);
  localparam int PROD_W  = CPR_W + COORD_W;
  localparam int IDX_W   = PROD_W + 1;

  typedef struct packed {
    op_t               op;
    logic              pixel_valid;
    logic              parity;
    logic              load_en;
    logic [ADDR_W-1:0] cell_addr;
    logic              cell_flip;
  } ctrl_t;

  logic [CELL_W-1:0]        s_eff;
  logic [CRW-1:0]           credits;
  logic                     issue;
  logic                     take_credit;
  ctrl_t                    ctrl_in;

  logic [DIV_LAT-1:0]       v_pipe;
  ctrl_t                    c_pipe [DIV_LAT];
  logic signed [DX_W-1:0]   qx;
  logic signed [DX_W-1:0]   qy;
  logic [CELL_W-1:0]        rx;
  logic [CELL_W-1:0]        ry;

  logic                     fold_x;
  logic                     fold_y;
  logic [CELL_W-1:0]        fx;
  logic [CELL_W-1:0]        fy;

  logic                     a_v;
  ctrl_t                    a_ctrl;
  logic [CELL_W-1:0]        a_x;
  logic [CELL_W-1:0]        a_y;
  logic                     a_par;
  logic                     a_neg;
  logic [COORD_W-1:0]       a_ic;
  logic [PROD_W-1:0]        a_prod;

  logic                     swap;
  logic                     b_v;
  ctrl_t                    b_ctrl;
  logic [CELL_W-1:0]        b_x;
  logic [CELL_W-1:0]        b_y;
  logic                     b_par;
  logic                     b_neg;
  logic [IDX_W-1:0]         b_idx;

  logic                     flip_mem [TABLE_DEPTH];
  logic                     c_v;
  ctrl_t                    c_ctrl;
  logic [CELL_W-1:0]        c_x;
  logic [CELL_W-1:0]        c_y;
  logic                     c_par;
  logic                     c_oor;
  logic                     flip_q;

  logic                     flip;
  logic signed [COORD_W-1:0] y_ext;

  assign s_eff = (cfg.cell_size == '0) ? CELL_W'(1) : cfg.cell_size;

  // pixel items reserve an output slot at issue, so the pipe never stalls
  assign issue       = mid_avail && ((mid.op == OP_LOAD) || (credits < CRW'(CAP)));
  assign mid_pop     = issue;
  assign take_credit = issue && (mid.op == OP_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      case ({take_credit, res_taken})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  always_comb begin
    ctrl_in.op          = mid.op;
    ctrl_in.pixel_valid = mid.pixel_valid;
    ctrl_in.parity      = mid.parity;
    ctrl_in.load_en     = mid.load_en;
    ctrl_in.cell_addr   = mid.cell_addr;
    ctrl_in.cell_flip   = mid.cell_flip;
  end

  kfold_div u_div_x (
    .clk (clk),
    .s   (s_eff),
    .d   (mid.dx),
    .q   (qx),
    .r   (rx)
  );

  kfold_div u_div_y (
    .clk (clk),
    .s   (s_eff),
    .d   (mid.dy),
    .q   (qy),
    .r   (ry)
  );

  // control rides alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe <= '0;
    end else begin
      v_pipe <= {v_pipe[DIV_LAT-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    c_pipe[0] <= ctrl_in;
    for (int k = 1; k < DIV_LAT; k++) begin
      c_pipe[k] <= c_pipe[k-1];
    end
  end

  // stage A: fold at half cell, start the table index
  assign fold_x = ({rx, 1'b0} > {1'b0, s_eff});
  assign fold_y = ({ry, 1'b0} > {1'b0, s_eff});
  assign fx     = fold_x ? (s_eff - rx) : rx;
  assign fy     = fold_y ? (s_eff - ry) : ry;

  always_ff @(posedge clk) begin
    a_ctrl <= c_pipe[DIV_LAT-1];
    a_x    <= fx;
    a_y    <= fy;
    a_par  <= c_pipe[DIV_LAT-1].parity ^ fold_x ^ fold_y;
    a_neg  <= qx[DX_W-1] | qy[DX_W-1];
    a_ic   <= qx[COORD_W-1:0];
    a_prod <= PROD_W'(cfg.cells_per_row) * PROD_W'(qy[COORD_W-1:0]);
  end

  // stage B: diagonal mirror, finish the index
  assign swap = (a_y > a_x);

  always_ff @(posedge clk) begin
    b_ctrl <= a_ctrl;
    b_x    <= swap ? a_y : a_x;
    b_y    <= swap ? a_x : a_y;
    b_par  <= a_par ^ swap;
    b_neg  <= a_neg;
    b_idx  <= IDX_W'(a_ic) + IDX_W'(a_prod);
  end

  // stage C: flip table, written by loads and read by pixels in stream order
  always_ff @(posedge clk) begin
    if (b_v && (b_ctrl.op == OP_LOAD) && b_ctrl.load_en) begin
      flip_mem[TAW'(b_ctrl.cell_addr)] <= b_ctrl.cell_flip;
    end
    flip_q <= flip_mem[b_idx[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    c_ctrl <= b_ctrl;
    c_x    <= b_x;
    c_y    <= b_y;
    c_par  <= b_par;
    c_oor  <= b_neg || (b_idx >= IDX_W'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      a_v <= v_pipe[DIV_LAT-1];
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  // result
  assign flip  = flip_q & ~c_oor;
  assign y_ext = COORD_W'(c_y);

  always_comb begin
    if (c_ctrl.pixel_valid) begin
      res.out_x             = COORD_W'(c_x);
      res.out_y             = flip ? -y_ext : y_ext;
      res.out_parity        = c_par ^ flip;
      res.out_valid         = 1'b1;
      res.cell_out_of_range = c_oor;
    end else begin
      res.out_x             = INVALID_MARK;
      res.out_y             = INVALID_MARK;
      res.out_parity        = 1'b0;
      res.out_valid         = 1'b0;
      res.cell_out_of_range = 1'b0;
    end
  end

  assign res_push = c_v && (c_ctrl.op == OP_MAP);

endmodule

// ----- rtl/kaleidoscope_442_fold_random.sv -----
`timescale 1ns / 1ps
// Path: from input transfer through the mid queue, the dividers and stages A to C to the result queue.
// Throughput: one item per cycle while pixel items find output credits; the 25-stage divider
// pipeline and the table read stage each take a new item every cycle.
// Reset: clears queues, credits and pipeline valids and loads register defaults;
// the flip table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// kaleidoscope_442_fold_random: *442 kaleidoscope fold
// Register file, front stage, mid queue, fold pipeline and result queue.
// ----------------------------------------------------------------------------
module kaleidoscope_442_fold_random #(
  parameter int FLIP_TABLE_DEPTH = 16384
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  kfold_pkg::in_item_t             din,
  output logic                            empty,
  input  logic                            pop,
  output kfold_pkg::out_item_t            dout,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kfold_pkg::PADDR_W-1:0]   paddr,
  input  logic [kfold_pkg::DATA_W-1:0]    pwdata,
  output logic [kfold_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import kfold_pkg::*;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2 ** $clog2(COORD_W + 16);
  localparam int CAP       = OUT_DEPTH + 1;

  cfg_t      cfg;
  reg_t      reg_sel;
  logic      cfg_wr;
  mid_item_t mid_d;
  mid_item_t mid_q;
  logic      mid_push;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_pop;
  out_item_t res;
  logic      res_push;
  logic      res_taken;

  assign pready  = 1'b1;
  assign reg_sel = reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size     <= CELL_W'(4096);
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.cells_per_row <= CPR_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CELL_SIZE:     cfg.cell_size     <= pwdata[CELL_W-1:0];
        REG_ORIGIN_X:      cfg.origin_x      <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:      cfg.origin_y      <= pwdata[COORD_W-1:0];
        REG_CELLS_PER_ROW: cfg.cells_per_row <= pwdata[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CELL_SIZE:     prdata = DATA_W'(cfg.cell_size);
      REG_ORIGIN_X:      prdata = DATA_W'(cfg.origin_x);
      REG_ORIGIN_Y:      prdata = DATA_W'(cfg.origin_y);
      REG_CELLS_PER_ROW: prdata = DATA_W'(cfg.cells_per_row);
      default:           prdata = '0;
    endcase
  end

  kfold_front #(
    .TABLE_DEPTH (FLIP_TABLE_DEPTH)
  ) u_front (
    .push     (push),
    .full     (full),
    .din      (din),
    .cfg      (cfg),
    .mid      (mid_d),
    .mid_push (mid_push),
    .mid_full (mid_full)
  );

  kfold_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_d),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_q),
    .empty (mid_empty)
  );

  kfold_back #(
    .TABLE_DEPTH (FLIP_TABLE_DEPTH),
    .CAP         (CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid       (mid_q),
    .mid_avail (!mid_empty),
    .mid_pop   (mid_pop),
    .res       (res),
    .res_push  (res_push),
    .res_taken (res_taken)
  );

  // credits in the back end keep this queue from ever filling
  assign res_taken = pop && !empty;

  kfold_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (),
    .pop   (pop),
    .dout  (dout),
    .empty (empty)
  );

endmodule

// ----- tb/sv/kaleidoscope_442_fold_random_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaleidoscope_442_fold_random_test: self-checking bench for the *442 fold
// Streams flip-table loads and pixels through the queue ports, predicts each
// folded result from a local copy of the registers and flip table, and checks
// every field of every result transfer in order. Registers change over APB
// between drained phases and are read back after each write.
// ----------------------------------------------------------------------------
module kaleidoscope_442_fold_random_test;
  import kfold_pkg::*;

  localparam int FLIP_DEPTH  = 16384;
  localparam int PIPE_SETTLE = 40;       // a bit over the pipeline latency
  localparam int CYCLE_LIMIT = 500000;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      push;
  logic                      full;
  in_item_t                  din;
  logic                      empty;
  logic                      pop;
  out_item_t                 dout;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // local copy of the register file and the flip table
  logic [CELL_W-1:0]         cell_size_m     = CELL_W'(4096);
  logic signed [COORD_W-1:0] origin_x_m      = '0;
  logic signed [COORD_W-1:0] origin_y_m      = '0;
  logic [CPR_W-1:0]          cells_per_row_m = CPR_W'(1);
  bit                        flip_bits   [FLIP_DEPTH];
  bit                        flip_loaded [FLIP_DEPTH];

  out_item_t                 fold_due [$];
  out_item_t                 fold_want;

  bit src_gaps;
  bit sink_gaps;
  int sink_hold_len = 0;
  int cycle_count   = 0;
  int n_errors      = 0;
  int n_checked     = 0;
  int n_maps        = 0;
  int n_invalid     = 0;
  int n_oor         = 0;
  int n_flipped     = 0;
  int n_loads       = 0;
  int n_settings    = 0;

  kaleidoscope_442_fold_random #(.FLIP_TABLE_DEPTH(FLIP_DEPTH)) dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic out_item_t fold_pixel(input in_item_t it, output int cell_idx);
    out_item_t res;
    longint    s, dx, dy, x, y, ic, jc, t, idx;
    logic      par;
    cell_idx = -1;
    res = '0;
    if (!it.pixel_valid) begin
      res.out_x = INVALID_MARK;
      res.out_y = INVALID_MARK;
      return res;
    end
    s = longint'(cell_size_m);
    if (s == 0) s = 1;
    dx = longint'(it.pos_x) - longint'(origin_x_m);
    dy = longint'(it.pos_y) - longint'(origin_y_m);
    // floor division, remainder kept in [0, s)
    ic = dx / s;
    x  = dx - ic * s;
    if (x < 0) begin
      ic--;
      x += s;
    end
    jc = dy / s;
    y  = dy - jc * s;
    if (y < 0) begin
      jc--;
      y += s;
    end
    par = it.parity_in;
    if (2 * x > s) begin
      x = s - x;
      par = ~par;
    end
    if (2 * y > s) begin
      y = s - y;
      par = ~par;
    end
    if (y > x) begin
      t = x;
      x = y;
      y = t;
      par = ~par;
    end
    res.out_valid = 1'b1;
    if (ic < 0 || jc < 0) begin
      res.cell_out_of_range = 1'b1;
    end else begin
      idx = ic + longint'(cells_per_row_m) * jc;
      if (idx >= FLIP_DEPTH) begin
        res.cell_out_of_range = 1'b1;
      end else begin
        cell_idx = int'(idx);
        if (flip_bits[cell_idx]) begin
          y = -y;
          par = ~par;
        end
      end
    end
    res.out_x      = x[COORD_W-1:0];
    res.out_y      = y[COORD_W-1:0];
    res.out_parity = par;
    return res;
  endfunction

  // ---------------------------------------------------------------- items
  function automatic in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t pixel(input longint px, py, input logic par, valid);
    in_item_t it;
    it = noise_item();
    it.op          = OP_MAP;
    it.pos_x       = px[COORD_W-1:0];
    it.pos_y       = py[COORD_W-1:0];
    it.parity_in   = par;
    it.pixel_valid = valid;
    return it;
  endfunction

  function automatic in_item_t flip_load(input logic [ADDR_W-1:0] addr, input logic flip);
    in_item_t it;
    it = noise_item();
    it.op        = OP_LOAD;
    it.cell_addr = addr;
    it.cell_flip = flip;
    return it;
  endfunction

  // offsets biased toward the fold points and the cell edges
  function automatic longint cell_offset(input longint s);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return s / 2;
      2: return (s / 2 + 1) % s;
      3: return s - 1;
      default: return longint'($urandom) % s;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    longint   s, ic, jc, rx, ry;
    int       ncols;
    it = noise_item();
    if ($urandom_range(0, 99) < 15) begin
      it.op = OP_LOAD;
      if ($urandom_range(0, 1)) it.cell_addr = ADDR_W'($urandom_range(0, 255));
      return it;
    end
    it.op          = OP_MAP;
    it.pixel_valid = ($urandom_range(0, 99) >= 8);
    if ($urandom_range(0, 9) < 3) return it;    // raw coordinates
    s = longint'(cell_size_m);
    if (s == 0) s = 1;
    ncols = (cells_per_row_m > 64) ? 64 : int'(cells_per_row_m);
    ic = $urandom_range(0, ncols - 1);
    jc = $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) ic = -1;
    if ($urandom_range(0, 9) == 0) jc = -1;
    rx = cell_offset(s);
    ry = ($urandom_range(0, 5) == 0) ? rx : cell_offset(s);
    rx = longint'(origin_x_m) + ic * s + rx;
    ry = longint'(origin_y_m) + jc * s + ry;
    it.pos_x = rx[COORD_W-1:0];
    it.pos_y = ry[COORD_W-1:0];
    return it;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic transfer_item(input in_item_t it);
    out_item_t want;
    int        idx;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    din  <= it;
    do @(posedge clk); while (full);
    // transfer taken at this edge; push stays up for the next item
    if (it.op == OP_LOAD) begin
      flip_bits[it.cell_addr]   = it.cell_flip;
      flip_loaded[it.cell_addr] = 1'b1;
      n_loads++;
    end else begin
      want = fold_pixel(it, idx);
      fold_due.push_back(want);
      n_maps++;
      if (!it.pixel_valid) n_invalid++;
      if (want.cell_out_of_range) n_oor++;
      if (idx >= 0 && flip_bits[idx]) n_flipped++;
    end
  endtask

  // a pixel landing on a never-loaded table entry gets its entry loaded first
  task automatic send_item(input in_item_t it);
    out_item_t probe;
    int        idx;
    if (it.op == OP_MAP) begin
      probe = fold_pixel(it, idx);
      if (idx >= 0 && !flip_loaded[idx])
        transfer_item(flip_load(ADDR_W'(idx), 1'($urandom)));
    end
    transfer_item(it);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic drain();
    push <= 1'b0;
    while (fold_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- registers
  task automatic write_reg(input reg_t r, input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] keep;
    case (r)
      REG_CELL_SIZE: begin
        keep = DATA_W'((1 << CELL_W) - 1);
        cell_size_m = v[CELL_W-1:0];
      end
      REG_ORIGIN_X: begin
        keep = DATA_W'((1 << COORD_W) - 1);
        origin_x_m = v[COORD_W-1:0];
      end
      REG_ORIGIN_Y: begin
        keep = DATA_W'((1 << COORD_W) - 1);
        origin_y_m = v[COORD_W-1:0];
      end
      default: begin
        keep = DATA_W'((1 << CPR_W) - 1);
        cells_per_row_m = v[CPR_W-1:0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & keep) !== (v & keep)) begin
      $error("register %s expected %0h got %0h", r.name(), v & keep, prdata & keep);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] cs, ox, oy, cpr);
    drain();
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELLS_PER_ROW, cpr);
    n_settings++;
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin : result_sink
    int n;
    forever begin
      if (sink_hold_len > 0) begin
        n = sink_hold_len;
        sink_hold_len = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (fold_due.size() == 0) begin
        $error("result transfer with nothing expected: %p", dout);
        n_errors++;
      end else begin
        fold_want = fold_due.pop_front();
        n_checked++;
        if (dout.out_x !== fold_want.out_x) begin
          $error("out_x expected %0d got %0d", fold_want.out_x, dout.out_x);
          n_errors++;
        end
        if (dout.out_y !== fold_want.out_y) begin
          $error("out_y expected %0d got %0d", fold_want.out_y, dout.out_y);
          n_errors++;
        end
        if (dout.out_parity !== fold_want.out_parity) begin
          $error("out_parity expected %0b got %0b", fold_want.out_parity, dout.out_parity);
          n_errors++;
        end
        if (dout.out_valid !== fold_want.out_valid) begin
          $error("out_valid expected %0b got %0b", fold_want.out_valid, dout.out_valid);
          n_errors++;
        end
        if (dout.cell_out_of_range !== fold_want.cell_out_of_range) begin
          $error("cell_out_of_range expected %0b got %0b",
                 fold_want.cell_out_of_range, dout.cell_out_of_range);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // reset settings: cell 1.0, origin 0, one cell per row
  task automatic test_directed();
    send_item(flip_load(ADDR_W'(0), 1'b0));
    send_item(flip_load(ADDR_W'(1), 1'b1));
    send_item(flip_load(ADDR_W'(2), 1'b1));
    send_item(flip_load('1, 1'b1));
    send_item(flip_load('1, 1'b0));
    send_item(pixel(0, 0, 1'b0, 1'b1));
    send_item(pixel(0, 0, 1'b1, 1'b1));
    send_item(pixel(2048, 0, 1'b0, 1'b1));       // exactly half: no fold
    send_item(pixel(2049, 0, 1'b0, 1'b1));
    send_item(pixel(0, 2048, 1'b1, 1'b1));       // diagonal swap only
    send_item(pixel(0, 2049, 1'b0, 1'b1));
    send_item(pixel(4095, 4095, 1'b0, 1'b1));    // both fold, x equals y
    send_item(pixel(1000, 3000, 1'b1, 1'b1));
    send_item(pixel(4096 + 100, 50, 1'b0, 1'b1)); // flipped cell
    send_item(pixel(8192 + 5, 1, 1'b1, 1'b1));
    send_item(pixel(-1, -1, 1'b0, 1'b1));        // negative cell
    send_item(pixel(-8388608, 8388607, 1'b1, 1'b1));
    send_item(pixel(8388607, -8388608, 1'b0, 1'b1));
    send_item(pixel(8388607, 8388607, 1'b1, 1'b1));
    send_item(pixel(0, 8388607, 1'b0, 1'b1));
    send_item(pixel(123, 456, 1'b1, 1'b0));      // invalid pixel
    send_item(pixel(-8388608, -8388608, 1'b1, 1'b0));
    drain();
  endtask

  task automatic test_register_extremes();
    set_config(1, 32'h007f_ffff, 32'hff80_0000, 16384);
    run_random(50);
    set_config(0, 32'hff80_0000, 32'h007f_ffff, 1);       // zero cell size acts as 1
    run_random(50);
    set_config(32'h007f_ffff, 32'hff80_0000, 32'hff80_0000, 3);
    run_random(50);
    set_config(4096, 0, 0, 128);
    run_random(50);
    set_config(2048, -1024, 512, 16383);
    run_random(50);
  endtask

  task automatic test_random_stream();
    repeat (5) begin
      set_config($urandom_range(256, 16384), $urandom_range(0, 8192) - 4096,
                 $urandom_range(0, 8192) - 4096, $urandom_range(1, 256));
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      run_random(65);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // receiver holds off while the sender keeps going, so the input stalls
  task automatic test_fill_and_stall();
    set_config(4096, 0, 0, 16);
    src_gaps = 1'b0;
    sink_hold_len = 400;
    run_random(140);
    drain();
    src_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    drain();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_random(70);
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    din       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_register_extremes();
    test_random_stream();
    test_fill_and_stall();
    test_steady_stream();
    drain();

    $display("pixels folded: %0d (%0d invalid, %0d outside table, %0d flipped), loads: %0d",
             n_maps, n_invalid, n_oor, n_flipped, n_loads);
    $display("register settings: %0d, results checked: %0d", n_settings, n_checked);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
